/* rtl/pal_pkg.sv */
// Shared types and constants for the prefix access list.
// No dependencies; imported by every module of the block but pal_ram.
`default_nettype none
package pal_pkg;
    localparam int ENTRIES   = 64;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int V4_BITS   = 32;
    localparam int V6_BITS   = 128;
    // Stored entry: family, hi, lo, len, deny, flags.
    localparam int ENTRY_W   = 1 + 64 + 64 + 8 + 1 + 16;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_LEN   = 2'd3
    } status_t;

    // A classified command as it travels from the front to the back.
    typedef struct packed {
        cmd_t        cmd;
        logic        fam;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  len;
        logic        deny;
        logic [15:0] flags;
        logic        bad;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    function automatic logic [63:0] mask_high(input logic [7:0] len);
        logic [63:0] m;
        m = '0;
        if (len >= 8'd64)
            m = '1;
        else if (len != 8'd0)
            m = ~(64'hFFFF_FFFF_FFFF_FFFF >> len[5:0]);
        return m;
    endfunction

    function automatic logic [63:0] mask_low(input logic [7:0] len);
        logic [63:0] m;
        logic [7:0]  r;
        m = '0;
        r = len - 8'd64;
        if (len >= 8'd128)
            m = '1;
        else if (len > 8'd64)
            m = ~(64'hFFFF_FFFF_FFFF_FFFF >> r[5:0]);
        return m;
    endfunction
endpackage
`default_nettype wire

/* rtl/pal_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module pal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/pal_front.sv */
// Front end: accepts words, classifies them and queues them for the back end.
// Depends on pal_pkg.
`default_nettype none
module pal_front
    import pal_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic        family,
    input  wire logic [63:0] addr_hi,
    input  wire logic [63:0] addr_lo,
    input  wire logic [7:0]  prefix_len,
    input  wire logic        deny,
    input  wire logic [15:0] user_flags,
    output logic             job_valid,
    input  wire logic        job_ready,
    output job_t             job
);
    job_t q_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    job_t cls;
    logic push, pop;
    logic [7:0] width;

    // Classify: mask the address for adds and deletes, flag bad lengths.
    always_comb
    begin
        width     = family ? 8'(V6_BITS) : 8'(V4_BITS);
        cls.cmd   = cmd_t'(command);
        cls.fam   = family;
        cls.len   = prefix_len;
        cls.deny  = deny;
        cls.flags = user_flags;
        cls.bad   = prefix_len > width;
        cls.hi    = addr_hi;
        cls.lo    = family ? addr_lo : 64'd0;
        if (cls.cmd != CMD_LOOKUP)
        begin
            cls.hi = cls.hi & mask_high(prefix_len);
            cls.lo = cls.lo & mask_low(prefix_len);
        end
    end

    assign in_ready  = cnt_reg != 2'd2;
    assign push      = in_valid && in_ready;
    assign job_valid = cnt_reg != 2'd0;
    assign pop       = job_valid && job_ready;
    assign job       = q_reg[rp_reg];

    // Two-deep queue between the two halves.
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

/* rtl/pal_back.sv */
// Back end: scans the entry table for each queued job and produces the result.
// Depends on pal_pkg and pal_ram.
`default_nettype none
module pal_back
    import pal_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        job_valid,
    output logic             job_ready,
    input  wire job_t        job,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             allowed,
    output logic             matched,
    output logic [15:0]      flags_out,
    output logic [1:0]       status
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DONE  = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    job_t job_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0] scan_reg;      // address being issued
    logic rd_vld_reg;                // read data valid this cycle
    logic [IDX_W-1:0] rd_idx_reg;
    logic hit_reg, best_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [7:0] best_len_reg;
    logic best_deny_reg;
    logic [15:0] best_flags_reg;
    logic [ENTRY_W-1:0] rdata, wdata;
    logic we;
    logic [IDX_W-1:0] waddr;
    logic e_fam, e_deny;
    logic [63:0] e_hi, e_lo;
    logic [7:0] e_len;
    logic [15:0] e_flags;
    logic exact, lpm, ev;
    logic free_found;
    logic [IDX_W-1:0] free_idx;
    logic out_valid_reg;
    logic allowed_reg, matched_reg;
    logic [15:0] flags_reg;
    logic [1:0] status_reg;

    assign {e_fam, e_hi, e_lo, e_len, e_deny, e_flags} = rdata;

    pal_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    // Compare the entry read last cycle with the job.
    always_comb
    begin
        ev    = rd_vld_reg && valid_reg[rd_idx_reg];
        exact = ev && e_fam == job_reg.fam && e_len == job_reg.len
                && e_hi == job_reg.hi && e_lo == job_reg.lo;
        lpm   = ev && !job_reg.bad && e_fam == job_reg.fam && e_len <= job_reg.len
                && (job_reg.hi & mask_high(e_len)) == e_hi
                && (job_reg.lo & mask_low(e_len)) == e_lo;
    end

    // Lowest free slot, from the valid flops.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Table write at the end of an add.
    always_comb
    begin
        we    = 1'b0;
        waddr = hit_reg ? hit_idx_reg : free_idx;
        wdata = {job_reg.fam, job_reg.hi, job_reg.lo, job_reg.len,
                 job_reg.deny, job_reg.flags};
        if (state_reg == S_DONE && job_reg.cmd == CMD_ADD && !job_reg.bad)
            we = hit_reg || free_found;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (job_valid)
                    state_next = S_SCAN;
            S_SCAN:
                if (!rd_vld_reg && scan_reg == CNT_W'(ENTRIES))
                    state_next = S_DONE;
            S_DONE:
                state_next = S_OUT;
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign job_ready = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign allowed   = allowed_reg;
    assign matched   = matched_reg;
    assign flags_out = flags_reg;
    assign status    = status_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
            job_reg <= job;
        if (state_reg == S_IDLE)
            best_len_reg <= '0;
        else if (lpm && (!best_reg || e_len > best_len_reg))
        begin
            best_len_reg   <= e_len;
            best_deny_reg  <= e_deny;
            best_flags_reg <= e_flags;
        end
        if (exact && !hit_reg)
            hit_idx_reg <= rd_idx_reg;
        rd_idx_reg <= scan_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            scan_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            best_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            allowed_reg   <= 1'b0;
            matched_reg   <= 1'b0;
            flags_reg     <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= state_reg == S_SCAN && scan_reg != CNT_W'(ENTRIES);
            if (state_reg == S_IDLE)
            begin
                scan_reg <= '0;
                hit_reg  <= 1'b0;
                best_reg <= 1'b0;
            end
            else
            begin
                if (state_reg == S_SCAN && scan_reg != CNT_W'(ENTRIES))
                    scan_reg <= scan_reg + CNT_W'(1);
                if (exact)
                    hit_reg <= 1'b1;
                if (lpm)
                    best_reg <= 1'b1;
            end
            if (we && !hit_reg)
                valid_reg[waddr] <= 1'b1;
            // Result word, held until taken.
            if (state_reg == S_DONE)
            begin
                out_valid_reg <= 1'b1;
                allowed_reg   <= 1'b0;
                matched_reg   <= 1'b0;
                flags_reg     <= '0;
                status_reg    <= ST_OK;
                case (job_reg.cmd)
                    CMD_LOOKUP:
                    begin
                        if (job_reg.bad)
                            status_reg <= ST_BAD_LEN;
                        if (best_reg)
                        begin
                            allowed_reg <= ~best_deny_reg;
                            matched_reg <= 1'b1;
                            flags_reg   <= best_flags_reg;
                        end
                        else
                            allowed_reg <= |valid_reg;
                    end
                    CMD_ADD:
                        if (job_reg.bad)
                            status_reg <= ST_BAD_LEN;
                        else if (!hit_reg && !free_found)
                            status_reg <= ST_FULL;
                    CMD_DELETE:
                        if (job_reg.bad)
                            status_reg <= ST_BAD_LEN;
                        else if (!hit_reg)
                            status_reg <= ST_NOT_FOUND;
                        else
                            valid_reg[hit_idx_reg] <= 1'b0;
                    default:
                        status_reg <= ST_OK;
                endcase
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

/* rtl/prefix_access_list.sv */
// Top level of the prefix access list: front end, queue and scanning back end.
// Depends on pal_pkg, pal_front and pal_back.
`default_nettype none
// Each command word (lookup, add or delete) is answered by one result word.
// Every command scans all ENTRIES table slots through one RAM read port; a
// word passes through the idle state to take the job, the scan including the
// read latency, a state to settle the result and one to present it, where it
// waits out any output stall; the front end queues up to two further words
// meanwhile. The table needs no clearing pass after reset: slot occupancy
// lives in flip-flops.
module prefix_access_list
    import pal_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic        family,
    input  wire logic [63:0] addr_hi,
    input  wire logic [63:0] addr_lo,
    input  wire logic [7:0]  prefix_len,
    input  wire logic        deny,
    input  wire logic [15:0] user_flags,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             allowed,
    output logic             matched,
    output logic [15:0]      flags_out,
    output logic [1:0]       status
);
    logic job_valid, job_ready;
    job_t job;

    pal_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .command, .family, .addr_hi,
        .addr_lo, .prefix_len, .deny, .user_flags,
        .job_valid, .job_ready, .job
    );

    pal_back u_back (
        .clk, .rst_n, .job_valid, .job_ready, .job,
        .out_valid, .out_ready, .allowed, .matched, .flags_out, .status
    );

`ifndef SYNTH
    // A result without a match always carries zero flags.
    a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> flags_out == 16'd0)
        else $error("flags without match");
    // Only lookups may match, and a matched result never reports a table error.
    a_match_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched |-> status == ST_OK || status == ST_BAD_LEN)
        else $error("match with bad status");
    // Results are never issued back to back from one scan.
    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result repeated");
`endif
endmodule
`default_nettype wire

/* test/pal_checker.sv */
// Checker for the prefix access list: watches both channels, predicts each result word.
// Depends on pal_pkg for the command and status codes and the family widths.
`timescale 1ns / 100ps
module pal_checker
    import pal_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [1:0]  command,
    input  wire logic        family,
    input  wire logic [63:0] addr_hi,
    input  wire logic [63:0] addr_lo,
    input  wire logic [7:0]  prefix_len,
    input  wire logic        deny,
    input  wire logic [15:0] user_flags,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic        allowed,
    input  wire logic        matched,
    input  wire logic [15:0] flags_out,
    input  wire logic [1:0]  status,
    output int               fail_count,
    output int               pending
);
    typedef struct packed {
        logic        allowed;
        logic        matched;
        logic [15:0] flags;
        status_t     status;
    } verdict_t;

    // Private copy of the prefix table.
    logic        tab_valid [ENTRIES];
    logic        tab_fam   [ENTRIES];
    logic [63:0] tab_hi    [ENTRIES];
    logic [63:0] tab_lo    [ENTRIES];
    logic [7:0]  tab_len   [ENTRIES];
    logic        tab_deny  [ENTRIES];
    logic [15:0] tab_flags [ENTRIES];

    verdict_t verdicts_due[$];

    function automatic logic [63:0] upper_mask(input logic [7:0] len);
        if (len == 8'd0)
            return 64'd0;
        if (len >= 8'd64)
            return '1;
        return ~({64{1'b1}} >> len);
    endfunction

    function automatic logic [63:0] lower_mask(input logic [7:0] len);
        if (len <= 8'd64)
            return 64'd0;
        if (len >= 8'd128)
            return '1;
        return ~({64{1'b1}} >> (len - 8'd64));
    endfunction

    // Applies one command word to the table and works out its result.
    task automatic apply_command(input cmd_t c, input logic fam, input logic [63:0] hi,
                                 input logic [63:0] lo_in, input logic [7:0] len,
                                 input logic dny, input logic [15:0] flg,
                                 output verdict_t v);
        logic [63:0] lo;
        logic [63:0] mh;
        logic [63:0] ml;
        logic        bad;
        logic        any;
        int          best;
        int          hit;
        lo = fam ? lo_in : 64'd0;
        bad = fam ? (len > V6_BITS) : (len > V4_BITS);
        v = '0;
        v.status = ST_OK;
        case (c)
            CMD_LOOKUP:
            begin
                any = 1'b0;
                best = -1;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (tab_valid[i])
                    begin
                        any = 1'b1;
                        if (!bad && tab_fam[i] == fam && tab_len[i] <= len &&
                            (hi & upper_mask(tab_len[i])) == tab_hi[i] &&
                            (lo & lower_mask(tab_len[i])) == tab_lo[i] &&
                            (best < 0 || tab_len[i] > tab_len[best]))
                            best = i;
                    end
                end
                if (bad)
                    v.status = ST_BAD_LEN;
                if (!any)
                    v.allowed = 1'b0;
                else if (best < 0)
                    v.allowed = 1'b1;
                else
                begin
                    v.allowed = !tab_deny[best];
                    v.matched = 1'b1;
                    v.flags = tab_flags[best];
                end
            end
            CMD_ADD, CMD_DELETE:
            begin
                if (bad)
                    v.status = ST_BAD_LEN;
                else
                begin
                    mh = hi & upper_mask(len);
                    ml = lo & lower_mask(len);
                    hit = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (hit < 0 && tab_valid[i] && tab_fam[i] == fam && tab_len[i] == len &&
                            tab_hi[i] == mh && tab_lo[i] == ml)
                            hit = i;
                    if (c == CMD_DELETE)
                    begin
                        if (hit < 0)
                            v.status = ST_NOT_FOUND;
                        else
                            tab_valid[hit] = 1'b0;
                    end
                    else
                    begin
                        // A new prefix takes the lowest free slot.
                        if (hit < 0)
                        begin
                            for (int i = 0; i < ENTRIES; i++)
                                if (hit < 0 && !tab_valid[i])
                                    hit = i;
                            if (hit >= 0)
                            begin
                                tab_valid[hit] = 1'b1;
                                tab_fam[hit] = fam;
                                tab_hi[hit] = mh;
                                tab_lo[hit] = ml;
                                tab_len[hit] = len;
                            end
                        end
                        if (hit < 0)
                            v.status = ST_FULL;
                        else
                        begin
                            tab_deny[hit] = dny;
                            tab_flags[hit] = flg;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Predict on every accepted command word, compare every accepted result word.
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        verdict_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                tab_valid[i] = 1'b0;
            verdicts_due.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_command(cmd_t'(command), family, addr_hi, addr_lo, prefix_len, deny,
                              user_flags, v);
                verdicts_due.push_back(v);
            end
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("result word with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (allowed !== want.allowed)
                    begin
                        $error("allowed: expected %0d, got %0d", want.allowed, allowed);
                        fail_count++;
                    end
                    if (matched !== want.matched)
                    begin
                        $error("matched: expected %0d, got %0d", want.matched, matched);
                        fail_count++;
                    end
                    if (flags_out !== want.flags)
                    begin
                        $error("flags_out: expected %h, got %h", want.flags, flags_out);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                end
            end
            pending = verdicts_due.size();
        end
    end
endmodule

/* test/tb_prefix_access_list.sv */
// Testbench top for the prefix access list: clock, reset, stimulus and verdict.
// Depends on pal_pkg, prefix_access_list and pal_checker.
`timescale 1ns / 100ps
module tb_prefix_access_list;
    import pal_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int FILL_COUNT  = 70;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic        family;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  prefix_len;
    logic        deny;
    logic [15:0] user_flags;
    logic        out_valid;
    logic        out_ready;
    logic        allowed;
    logic        matched;
    logic [15:0] flags_out;
    logic [1:0]  status;
    int          fail_count;
    int          pending;

    logic        idle_on;
    logic        calm;
    int          stall_left;
    int          quiet_cycles;
    logic [63:0] pool_hi [16];
    logic [63:0] pool_lo [16];
    logic [63:0] fill_hi [FILL_COUNT];

    prefix_access_list uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .family(family), .addr_hi(addr_hi), .addr_lo(addr_lo),
        .prefix_len(prefix_len), .deny(deny), .user_flags(user_flags),
        .out_valid(out_valid), .out_ready(out_ready), .allowed(allowed),
        .matched(matched), .flags_out(flags_out), .status(status)
    );

    pal_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .family(family), .addr_hi(addr_hi), .addr_lo(addr_lo),
        .prefix_len(prefix_len), .deny(deny), .user_flags(user_flags),
        .out_valid(out_valid), .out_ready(out_ready), .allowed(allowed),
        .matched(matched), .flags_out(flags_out), .status(status),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side back-pressure in short random bursts.
    always @(posedge clk)
    begin
        if (calm || !idle_on)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one command word and returns at the edge where it is taken.
    task automatic send_word(input cmd_t c, input logic fam, input logic [63:0] hi,
                             input logic [63:0] lo, input logic [7:0] len,
                             input logic dny, input logic [15:0] flg);
        if (!calm && idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        family <= fam;
        addr_hi <= hi;
        addr_lo <= lo;
        prefix_len <= len;
        deny <= dny;
        user_flags <= flg;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // A random word, mostly built around a small pool of prefixes so that matches occur.
    task automatic send_random_word();
        cmd_t        c;
        logic        fam;
        logic [63:0] hi;
        logic [63:0] lo;
        int          width;
        int          len;
        int          k;
        int          pick;
        fam = 1'($urandom_range(0, 1));
        width = fam ? V6_BITS : V4_BITS;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            c = CMD_LOOKUP;
        else if (pick < 75)
            c = CMD_ADD;
        else if (pick < 95)
            c = CMD_DELETE;
        else
            c = CMD_NONE;
        k = $urandom_range(0, 15);
        if ($urandom_range(0, 6) == 0)
        begin
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
        end
        else
        begin
            hi = pool_hi[k];
            lo = pool_lo[k];
        end
        if ($urandom_range(0, 9) == 0)
            len = $urandom_range(width + 1, 255);
        else if (c == CMD_LOOKUP && $urandom_range(0, 1) == 0)
            len = width;
        else
            len = $urandom_range(0, width);
        // Lookups vary the low address bits while keeping the leading ones.
        if (c == CMD_LOOKUP)
        begin
            hi = hi ^ ({$urandom, $urandom} >> $urandom_range(0, 63));
            lo = lo ^ ({$urandom, $urandom} >> $urandom_range(0, 63));
        end
        send_word(c, fam, hi, lo, len[7:0], 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        command <= CMD_LOOKUP;
        family <= 1'b0;
        addr_hi <= '0;
        addr_lo <= '0;
        prefix_len <= '0;
        deny <= 1'b0;
        user_flags <= '0;
        out_ready <= 1'b0;
        stall_left <= 0;
        quiet_cycles <= 0;
        idle_on = 1'b1;
        calm = 1'b0;
        for (int i = 0; i < 16; i++)
        begin
            pool_hi[i] = {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: empty table, bad lengths, update, match, miss and removal.
        send_word(CMD_LOOKUP, 1'b0, 64'hC0A8_0105_0000_0000, '0, 8'd32, 1'b0, '0);
        send_word(CMD_LOOKUP, 1'b0, 64'hC0A8_0105_0000_0000, '0, 8'd33, 1'b0, '0);
        send_word(CMD_ADD, 1'b0, 64'hC0A8_01FF_0000_0000, '1, 8'd24, 1'b0, 16'hFFFF);
        send_word(CMD_ADD, 1'b0, '0, '0, 8'd0, 1'b1, 16'h0001);
        send_word(CMD_ADD, 1'b1, '1, '1, 8'd128, 1'b1, 16'h8000);
        send_word(CMD_ADD, 1'b0, 64'hC0A8_0100_0000_0000, '0, 8'd24, 1'b1, 16'h1234);
        send_word(CMD_LOOKUP, 1'b0, 64'hC0A8_0105_0000_0000, '1, 8'd32, 1'b0, '0);
        send_word(CMD_LOOKUP, 1'b0, 64'h0A00_0001_0000_0000, '0, 8'd32, 1'b0, '0);
        send_word(CMD_LOOKUP, 1'b1, 64'h2001_0DB8_0000_0000, 64'd1, 8'd128, 1'b0, '0);
        send_word(CMD_LOOKUP, 1'b1, '1, '1, 8'd128, 1'b0, '0);
        send_word(CMD_LOOKUP, 1'b1, '1, '1, 8'd129, 1'b0, '0);
        send_word(CMD_ADD, 1'b1, '1, '1, 8'd200, 1'b0, 16'hFFFF);
        send_word(CMD_ADD, 1'b0, '1, '0, 8'd33, 1'b0, 16'hFFFF);
        send_word(CMD_DELETE, 1'b0, 64'hC0A8_0100_0000_0000, '0, 8'd16, 1'b0, '0);
        send_word(CMD_DELETE, 1'b0, 64'hC0A8_0100_0000_0000, '0, 8'd24, 1'b0, '0);
        send_word(CMD_NONE, 1'b1, '1, '1, 8'hFF, 1'b1, 16'hFFFF);
        send_word(CMD_LOOKUP, 1'b0, 64'hC0A8_0105_0000_0000, '0, 8'd16, 1'b0, '0);
        send_word(CMD_ADD, 1'b1, '0, '0, 8'd64, 1'b0, 16'h00FF);
        send_word(CMD_LOOKUP, 1'b1, '0, '1, 8'd64, 1'b0, '0);
        send_word(CMD_DELETE, 1'b0, '0, '0, 8'd0, 1'b0, '0);
        send_word(CMD_DELETE, 1'b1, '1, '1, 8'd128, 1'b0, '0);
        send_word(CMD_DELETE, 1'b1, '0, '0, 8'd64, 1'b0, '0);
        send_word(CMD_LOOKUP, 1'b1, '0, '0, 8'd128, 1'b0, '0);

        // Fill the table past its capacity, then drain before reading it back.
        for (int i = 0; i < FILL_COUNT; i++)
        begin
            fill_hi[i] = {$urandom, $urandom};
            send_word(CMD_ADD, 1'b1, fill_hi[i], 64'(i), 8'd128, 1'($urandom_range(0, 1)),
                      16'($urandom_range(0, 65535)));
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        for (int i = 0; i < FILL_COUNT; i++)
            send_word(CMD_DELETE, 1'b1, fill_hi[i], 64'(i), 8'd128, 1'b0, '0);

        // Random words, with idling switched off in stretches and for the last part.
        for (int i = 0; i < 780; i++)
        begin
            if (i % 150 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (i == 660)
                calm = 1'b1;
            send_random_word();
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
